[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file utf8d_checker.sv.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[hw/rtl/utf8d_pkg.sv]
// Shared types and constants of the UTF-8 stream decoder.
// No dependencies.
package utf8d_pkg;

    typedef enum logic [1:0] {
        STAT_CP   = 2'd0,
        STAT_ERR  = 2'd1,
        STAT_DONE = 2'd2
    } status_t;

    localparam int CP_W        = 21;
    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_TUSER_W = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_FATAL_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEEP_BOM   = 1'd1;

    localparam logic [CP_W-1:0] CP_BOM    = 21'h00FEFF;
    localparam logic [CP_W-1:0] CP_REPL   = 21'h00FFFD;
    localparam logic [7:0]      LIMIT_LOW = 8'h80;
    localparam logic [7:0]      LIMIT_HIGH = 8'hBF;

    typedef struct packed {
        logic [1:0]      needed_count;
        logic [1:0]      seen_count;
        logic [7:0]      low_limit;
        logic [7:0]      high_limit;
        logic [CP_W-1:0] partial_value;
        logic            first_done;
    } state_t;

    localparam state_t STATE_RESET = '{
        needed_count:  2'd0,
        seen_count:    2'd0,
        low_limit:     LIMIT_LOW,
        high_limit:    LIMIT_HIGH,
        partial_value: '0,
        first_done:    1'b0
    };

    typedef struct packed {
        logic [CP_W-1:0] cp_value;
        status_t         status;
        logic            last;
    } result_t;

endpackage

[hw/rtl/utf8d_core.sv]
// Decode step of the UTF-8 stream decoder: state and one input beat in,
// next state and up to two results out. Depends on utf8d_pkg.
module utf8d_core (
    input  utf8d_pkg::state_t  state_q,
    input  logic               fatal_mode,
    input  logic               keep_bom,
    input  logic [7:0]         data_byte,
    input  logic               is_end,
    input  logic               flush,
    output utf8d_pkg::state_t  state_d,
    output logic [1:0]         res_count,
    output utf8d_pkg::result_t res0,
    output utf8d_pkg::result_t res1
);
    import utf8d_pkg::*;

    typedef enum logic [1:0] {
        LEAD_NONE,
        LEAD_CP,
        LEAD_ERR
    } lead_t;

    lead_t           l_kind;
    logic [1:0]      l_needed;
    logic [7:0]      l_low;
    logic [7:0]      l_high;
    logic [CP_W-1:0] l_partial;

    state_t     st;
    logic [1:0] n;
    logic       do_lead;
    result_t    res_v [2];

    always_comb begin
        l_kind    = LEAD_NONE;
        l_needed  = 2'd0;
        l_low     = LIMIT_LOW;
        l_high    = LIMIT_HIGH;
        l_partial = '0;
        if (data_byte <= 8'h7F) begin
            l_kind    = LEAD_CP;
            l_partial = {{(CP_W-8){1'b0}}, data_byte};
        end else if (data_byte <= 8'hC1) begin
            l_kind = LEAD_ERR;
        end else if (data_byte <= 8'hDF) begin
            l_needed  = 2'd1;
            l_partial = {{(CP_W-5){1'b0}}, data_byte[4:0]};
        end else if (data_byte <= 8'hEF) begin
            l_needed  = 2'd2;
            l_partial = {{(CP_W-4){1'b0}}, data_byte[3:0]};
            if (data_byte == 8'hE0) l_low = 8'hA0;
            if (data_byte == 8'hED) l_high = 8'h9F;
        end else if (data_byte <= 8'hF4) begin
            l_needed  = 2'd3;
            l_partial = {{(CP_W-3){1'b0}}, data_byte[2:0]};
            if (data_byte == 8'hF0) l_low = 8'h90;
            if (data_byte == 8'hF4) l_high = 8'h8F;
        end else begin
            l_kind = LEAD_ERR;
        end
    end

    always_comb begin
        st       = state_q;
        n        = 2'd0;
        do_lead  = 1'b0;
        res_v[0] = '0;
        res_v[1] = '0;

        if (is_end) begin
            if (flush) begin
                if (st.needed_count != 2'd0 && fatal_mode) begin
                    res_v[n[0]] = '{cp_value: '0, status: STAT_ERR, last: 1'b0};
                    n = n + 2'd1;
                end else begin
                    if (st.needed_count != 2'd0) begin
                        res_v[n[0]] = '{cp_value: CP_REPL, status: STAT_CP, last: 1'b0};
                        n = n + 2'd1;
                    end
                    res_v[n[0]] = '{cp_value: '0, status: STAT_DONE, last: 1'b0};
                    n = n + 2'd1;
                end
                st = STATE_RESET;
            end
        end else if (st.needed_count == 2'd0) begin
            do_lead = 1'b1;
        end else if (data_byte < st.low_limit || data_byte > st.high_limit) begin
            st.needed_count = 2'd0;
            st.seen_count   = 2'd0;
            st.low_limit    = LIMIT_LOW;
            st.high_limit   = LIMIT_HIGH;
            if (fatal_mode) begin
                res_v[n[0]] = '{cp_value: '0, status: STAT_ERR, last: 1'b0};
                n = n + 2'd1;
                st = STATE_RESET;
            end else begin
                res_v[n[0]] = '{cp_value: CP_REPL, status: STAT_CP, last: 1'b0};
                n = n + 2'd1;
                st.first_done = 1'b1;
                do_lead = 1'b1;
            end
        end else begin
            st.low_limit     = LIMIT_LOW;
            st.high_limit    = LIMIT_HIGH;
            st.partial_value = {st.partial_value[CP_W-7:0], data_byte[5:0]};
            st.seen_count    = st.seen_count + 2'd1;
            if (st.seen_count == st.needed_count) begin
                st.seen_count   = 2'd0;
                st.needed_count = 2'd0;
                if (st.first_done || keep_bom || st.partial_value != CP_BOM) begin
                    res_v[n[0]] = '{cp_value: st.partial_value, status: STAT_CP,
                                    last: 1'b0};
                    n = n + 2'd1;
                end
                st.first_done = 1'b1;
            end
        end

        if (do_lead) begin
            unique case (l_kind)
                LEAD_NONE: begin
                    st.needed_count  = l_needed;
                    st.low_limit     = l_low;
                    st.high_limit    = l_high;
                    st.partial_value = l_partial;
                end
                LEAD_CP: begin
                    st.partial_value = l_partial;
                    res_v[n[0]] = '{cp_value: l_partial, status: STAT_CP, last: 1'b0};
                    n = n + 2'd1;
                    st.first_done = 1'b1;
                end
                LEAD_ERR: begin
                    if (fatal_mode) begin
                        res_v[n[0]] = '{cp_value: '0, status: STAT_ERR, last: 1'b0};
                        n = n + 2'd1;
                        st = STATE_RESET;
                    end else begin
                        res_v[n[0]] = '{cp_value: CP_REPL, status: STAT_CP,
                                        last: 1'b0};
                        n = n + 2'd1;
                        st.first_done = 1'b1;
                    end
                end
                default: begin
                    st = st;
                end
            endcase
        end

        if (n != 2'd0) begin
            res_v[~n[0]].last = 1'b1;
        end
    end

    assign state_d   = st;
    assign res_count = n;
    assign res0      = res_v[0];
    assign res1      = res_v[1];

endmodule

[hw/rtl/utf8d_queue.sv]
// Result queue of the UTF-8 stream decoder: a short shift queue that takes up
// to two results per cycle and gives one per cycle when popped. Depends on utf8d_pkg.
module utf8d_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic [1:0]         push_count,
    input  utf8d_pkg::result_t push0,
    input  utf8d_pkg::result_t push1,
    input  logic               pop,
    output utf8d_pkg::result_t head,
    output logic               not_empty,
    output logic               has_room
);
    import utf8d_pkg::*;

    result_t             entry_reg [QUEUE_DEPTH];
    result_t             entry_next [QUEUE_DEPTH];
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic [QCNT_W-1:0]   base;

    assign base = count_reg - {{(QCNT_W-1){1'b0}}, pop};

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (pop) begin
                entry_next[i] = (i == QUEUE_DEPTH - 1) ? entry_reg[i] : entry_reg[(i + 1) % QUEUE_DEPTH];
            end else begin
                entry_next[i] = entry_reg[i];
            end
            if (push_count != 2'd0 && QCNT_W'(i) == base) begin
                entry_next[i] = push0;
            end
            if (push_count == 2'd2 && QCNT_W'(i) == base + QCNT_W'(1)) begin
                entry_next[i] = push1;
            end
        end
        count_next = base + {{(QCNT_W-2){1'b0}}, push_count};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            entry_reg[i] <= entry_next[i];
        end
    end

    assign head      = entry_reg[0];
    assign not_empty = (count_reg != '0);
    assign has_room  = (count_reg <= QCNT_W'(QUEUE_DEPTH - 2));

endmodule

[hw/rtl/utf8_stream_decoder_unit.sv]
// Top level of the UTF-8 stream decoder: config registers, stream state,
// decode step and result queue. Depends on utf8d_pkg, utf8d_core, utf8d_queue.
//
// One input beat (a byte or an end marker) is taken every cycle while the
// queue has room, and is decoded in the same cycle against the stored stream
// state; its zero, one or two results go into a four-entry result queue that
// drives the output channel. Steady throughput is one byte per cycle while
// the output is ready. A beat that yields two results (in non-fatal mode, a
// rejected continuation byte that is itself ASCII or invalid, or a flush of
// an incomplete sequence) occupies two output beats, so s_tready drops when
// more than two results wait in the queue. Configuration writes are always ready.
module utf8_stream_decoder_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [utf8d_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic [utf8d_pkg::IN_TUSER_W-1:0]  s_tuser,   // [0] is_end, [1] flush
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [utf8d_pkg::OUT_TDATA_W-1:0] m_tdata,   // [20:0] cp_value, [23:21] zero
    output logic [utf8d_pkg::OUT_TUSER_W-1:0] m_tuser,   // [1:0] status
    output logic                              m_tlast,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [utf8d_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic                              cfg_wdata
);
    import utf8d_pkg::*;

    logic       fatal_mode_reg;
    logic       keep_bom_reg;
    state_t     state_reg;
    state_t     state_next;
    state_t     core_state;
    logic [1:0] core_count;
    result_t    core_res0;
    result_t    core_res1;
    logic       in_beat;
    logic       has_room;
    logic       not_empty;
    result_t    head;

    assign cfg_ready = 1'b1;
    assign s_tready  = has_room;
    assign in_beat   = s_tvalid && s_tready;

    utf8d_core u_core (
        .state_q    (state_reg),
        .fatal_mode (fatal_mode_reg),
        .keep_bom   (keep_bom_reg),
        .data_byte  (s_tdata[7:0]),
        .is_end     (s_tuser[0]),
        .flush      (s_tuser[1]),
        .state_d    (core_state),
        .res_count  (core_count),
        .res0       (core_res0),
        .res1       (core_res1)
    );

    utf8d_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (in_beat ? core_count : 2'd0),
        .push0      (core_res0),
        .push1      (core_res1),
        .pop        (m_tvalid && m_tready),
        .head       (head),
        .not_empty  (not_empty),
        .has_room   (has_room)
    );

    assign state_next = in_beat ? core_state : state_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fatal_mode_reg <= 1'b0;
            keep_bom_reg   <= 1'b0;
            state_reg      <= STATE_RESET;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_FATAL_MODE: fatal_mode_reg <= cfg_wdata;
                    REG_KEEP_BOM:   keep_bom_reg   <= cfg_wdata;
                    default:        fatal_mode_reg <= fatal_mode_reg;
                endcase
            end
            state_reg <= state_next;
        end
    end

    assign m_tvalid = not_empty;
    assign m_tdata  = {{(OUT_TDATA_W-CP_W){1'b0}}, head.cp_value};
    assign m_tuser  = head.status;
    assign m_tlast  = head.last;

endmodule

[hw/rtl/utf8d_checker.sv]
// Port-level checks of the UTF-8 stream decoder, bound to the top level.
// Depends on utf8d_pkg and assert_macros.svh.
`include "assert_macros.svh"

module utf8d_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [utf8d_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic [utf8d_pkg::OUT_TUSER_W-1:0] m_tuser,
    input logic                              m_tlast
);
    import utf8d_pkg::*;

    logic [CP_W-1:0] cp;
    logic [1:0]      stat;
    logic            is_cp;
    logic            status_ok;
    logic            scalar_ok;

    assign cp        = m_tdata[CP_W-1:0];
    assign stat      = m_tuser;
    assign is_cp     = (stat == STAT_CP);
    assign status_ok = is_cp || (cp == '0 && (stat == STAT_ERR || stat == STAT_DONE));
    assign scalar_ok = (cp <= 21'h10FFFF) && (cp < 21'h00D800 || cp > 21'h00DFFF);

    `ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `ASSERT_IMPLY(a_status_code, aclk, aresetn, m_tvalid, status_ok)
    `ASSERT_IMPLY(a_end_is_last, aclk, aresetn, m_tvalid && !is_cp, m_tlast)
    `ASSERT_IMPLY(a_scalar, aclk, aresetn, m_tvalid && is_cp, scalar_ok)

endmodule

bind utf8_stream_decoder_unit utf8d_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
